// ----- hdl/tcrr_pkg.sv -----
// tcrr_pkg: shared types and constants of the two-class round-robin scheduler
// no dependencies; used by the channel interfaces and the core
package tcrr_pkg;

   localparam int SLOTS   = 8;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FUNC_W  = 3;
   localparam int TASK_W  = 8;
   localparam int WORD_W  = 32;
   localparam int TABLES  = 2;

   localparam logic TBL_LOW  = 1'b0;
   localparam logic TBL_HIGH = 1'b1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SCHEDULE = 3'd0,
      FUNC_ADD      = 3'd1,
      FUNC_EXIT     = 3'd2,
      FUNC_WAIT     = 3'd3,
      FUNC_NOTIFY   = 3'd4,
      FUNC_SLEEP    = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      PH_H1 = 3'd0,
      PH_L1 = 3'd1,
      PH_H2 = 3'd2,
      PH_L2 = 3'd3,
      PH_H3 = 3'd4
   } phase_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

endpackage

// ----- hdl/tcrr_if.sv -----
// tcrr_req_if, tcrr_rsp_if: valid/ready channels of the scheduler
// depends on tcrr_pkg for field widths
interface tcrr_req_if;
   logic                             valid;
   logic                             ready;
   logic [tcrr_pkg::FUNC_W-1:0]      func;
   logic [tcrr_pkg::TASK_W-1:0]      task_id;
   logic                             high_priority;
   logic [tcrr_pkg::WORD_W-1:0]      now_ticks;
   logic [tcrr_pkg::WORD_W-1:0]      reason;
   logic [tcrr_pkg::WORD_W-1:0]      check_count;
   logic [tcrr_pkg::WORD_W-1:0]      wake_time;

   modport source (output valid, func, task_id, high_priority, now_ticks, reason,
                   check_count, wake_time, input ready);
   modport sink   (input valid, func, task_id, high_priority, now_ticks, reason,
                   check_count, wake_time, output ready);
endinterface

interface tcrr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tcrr_pkg::TASK_W-1:0]      chosen_task;
   logic                             is_idle;
   logic                             accepted;
   logic [tcrr_pkg::WORD_W-1:0]      notify_total;

   modport source (output valid, chosen_task, is_idle, accepted, notify_total,
                   input ready);
   modport sink   (input valid, chosen_task, is_idle, accepted, notify_total,
                   output ready);
endinterface

// ----- hdl/two_class_round_robin_scheduler_core.sv -----
// two_class_round_robin_scheduler_core: slot tables, phase sequencer, scan unit
// depends on tcrr_pkg and the channel interfaces in tcrr_if.sv
//
// channel  dir  modport             contents
// req      in   tcrr_req_if.sink    func, task id, priority, ticks, reason, count, wake
// rsp      out  tcrr_rsp_if.source  chosen task, idle, accepted, notify total
//
// one request is worked at a time; req.ready is high only while idle
// schedule scans 1 to SLOTS slots of one table after the accept, one per cycle unless rsp stalls
// add scans up to SLOTS slots; exit, wait, notify and sleep scan all SLOTS slot columns
// (both tables checked in each column); unknown codes finish without a scan after accept
// the scan unit holds while a finished response still waits on rsp.ready
// synchronous reset clears state, response valid, slot valid and flag bits, pointer, phase and counter
module two_class_round_robin_scheduler_core (
   input  logic clock,
   input  logic reset,
   tcrr_req_if.sink   req,
   tcrr_rsp_if.source rsp
);
   import tcrr_pkg::*;

   state_type               state_ff, state_in;
   func_type                func_ff, func_in;
   logic [TASK_W-1:0]       id_ff, id_in;
   logic                    sel_ff, sel_in;
   logic [WORD_W-1:0]       opnd_ff, opnd_in;
   logic                    check_ok_ff, check_ok_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic                    acc_ff, acc_in;
   phase_type               phase_ff, phase_in;
   logic [SLOT_W-1:0]       ptr_ff, ptr_in;
   logic [WORD_W-1:0]       notify_ff, notify_in;

   logic                    used_ff  [TABLES][SLOTS];
   logic                    used_in  [TABLES][SLOTS];
   logic                    wait_ff  [TABLES][SLOTS];
   logic                    wait_in  [TABLES][SLOTS];
   logic                    sleep_ff [TABLES][SLOTS];
   logic                    sleep_in [TABLES][SLOTS];
   logic [TASK_W-1:0]       task_ff  [TABLES][SLOTS];
   logic [TASK_W-1:0]       task_in  [TABLES][SLOTS];
   logic [WORD_W-1:0]       word_ff  [TABLES][SLOTS];
   logic [WORD_W-1:0]       word_in  [TABLES][SLOTS];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TASK_W-1:0]       chosen_ff, chosen_in;
   logic                    idle_ff, idle_in;
   logic                    accepted_ff, accepted_in;
   logic [WORD_W-1:0]       total_ff, total_in;

   phase_type               phase_next;
   logic [SLOT_W-1:0]       cand;
   logic [SLOT_W-1:0]       scan_idx;
   logic                    last;
   logic                    can_finish;
   logic                    finish;
   logic                    hit   [TABLES];
   logic                    wmatch[TABLES];
   logic                    s_used, s_wait, s_sleep, s_le;
   logic                    any_hit;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_H1;
         ptr_ff       <= '0;
         notify_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TABLES; t++) begin
            for (int s = 0; s < SLOTS; s++) begin
               used_ff[t][s]  <= 1'b0;
               wait_ff[t][s]  <= 1'b0;
               sleep_ff[t][s] <= 1'b0;
            end
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ptr_ff       <= ptr_in;
         notify_ff    <= notify_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         wait_ff      <= wait_in;
         sleep_ff     <= sleep_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      id_ff       <= id_in;
      sel_ff      <= sel_in;
      opnd_ff     <= opnd_in;
      check_ok_ff <= check_ok_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      task_ff     <= task_in;
      word_ff     <= word_in;
      chosen_ff   <= chosen_in;
      idle_ff     <= idle_in;
      accepted_ff <= accepted_in;
      total_ff    <= total_in;
   end

   always_comb begin
      unique case (phase_ff)
         PH_H1:   phase_next = PH_L1;
         PH_L1:   phase_next = PH_H2;
         PH_H2:   phase_next = PH_L2;
         PH_L2:   phase_next = PH_H3;
         default: phase_next = PH_H1;
      endcase
   end

   // shared scan unit: one slot column per cycle unless a finished response waits on rsp.ready
   always_comb begin
      cand     = (ptr_ff == SLOT_W'(SLOTS - 1)) ? '0 : SLOT_W'(ptr_ff + SLOT_W'(1));
      scan_idx = (func_ff == FUNC_SCHEDULE) ? cand : idx_ff;
      last     = (idx_ff == SLOT_W'(SLOTS - 1));
      for (int t = 0; t < TABLES; t++) begin
         hit[t]    = used_ff[t][scan_idx] && (task_ff[t][scan_idx] == id_ff);
         wmatch[t] = used_ff[t][scan_idx] && wait_ff[t][scan_idx] &&
                     (word_ff[t][scan_idx] == opnd_ff);
      end
      any_hit = hit[0] || hit[1];
      s_used  = used_ff[sel_ff][scan_idx];
      s_wait  = wait_ff[sel_ff][scan_idx];
      s_sleep = sleep_ff[sel_ff][scan_idx];
      s_le    = (word_ff[sel_ff][scan_idx] <= opnd_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      sel_in       = sel_ff;
      opnd_in      = opnd_ff;
      check_ok_in  = check_ok_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      phase_in     = phase_ff;
      ptr_in       = ptr_ff;
      notify_in    = notify_ff;
      used_in      = used_ff;
      wait_in      = wait_ff;
      sleep_in     = sleep_ff;
      task_in      = task_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      chosen_in    = chosen_ff;
      idle_in      = idle_ff;
      accepted_in  = accepted_ff;
      total_in     = total_ff;
      finish       = 1'b0;

      req.ready    = (state_ff == ST_IDLE);
      can_finish   = !rsp_valid_ff || rsp.ready;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in     = func_type'(req.func);
               id_in       = req.task_id;
               idx_in      = '0;
               acc_in      = 1'b0;
               check_ok_in = (req.check_count == notify_ff);
               sel_in      = req.high_priority;
               unique case (func_type'(req.func))
                  FUNC_SCHEDULE: opnd_in = req.now_ticks;
                  FUNC_SLEEP:    opnd_in = req.wake_time;
                  default:       opnd_in = req.reason;
               endcase
               if (func_type'(req.func) == FUNC_SCHEDULE) begin
                  phase_in = phase_next;
                  sel_in   = (phase_next == PH_L1 || phase_next == PH_L2) ?
                             TBL_LOW : TBL_HIGH;
               end
               if (func_type'(req.func) == FUNC_NOTIFY) begin
                  notify_in = notify_ff + WORD_W'(1);
               end
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (can_finish) begin
               idx_in      = SLOT_W'(idx_ff + SLOT_W'(1));
               chosen_in   = '0;
               idle_in     = 1'b0;
               accepted_in = 1'b0;
               unique case (func_ff)
                  FUNC_SCHEDULE: begin
                     ptr_in = cand;
                     if (s_used && !s_wait && (!s_sleep || s_le)) begin
                        sleep_in[sel_ff][scan_idx] = 1'b0;
                        chosen_in = task_ff[sel_ff][scan_idx];
                        finish    = 1'b1;
                     end else if (last) begin
                        idle_in = 1'b1;
                        finish  = 1'b1;
                     end
                  end
                  FUNC_ADD: begin
                     if (!s_used) begin
                        used_in[sel_ff][scan_idx]  = 1'b1;
                        task_in[sel_ff][scan_idx]  = id_ff;
                        wait_in[sel_ff][scan_idx]  = 1'b0;
                        sleep_in[sel_ff][scan_idx] = 1'b0;
                        word_in[sel_ff][scan_idx]  = '0;
                        accepted_in = 1'b1;
                        finish      = 1'b1;
                     end else if (last) begin
                        finish = 1'b1;
                     end
                  end
                  FUNC_EXIT: begin
                     for (int t = 0; t < TABLES; t++) begin
                        if (hit[t]) used_in[t][scan_idx] = 1'b0;
                     end
                     finish = last;
                  end
                  FUNC_WAIT: begin
                     if (check_ok_ff) begin
                        for (int t = 0; t < TABLES; t++) begin
                           if (hit[t]) begin
                              word_in[t][scan_idx] = opnd_ff;
                              wait_in[t][scan_idx] = 1'b1;
                           end
                        end
                        acc_in = acc_ff || any_hit;
                     end
                     accepted_in = check_ok_ff && (acc_ff || any_hit);
                     finish      = last;
                  end
                  FUNC_NOTIFY: begin
                     for (int t = 0; t < TABLES; t++) begin
                        if (wmatch[t]) begin
                           word_in[t][scan_idx] = '0;
                           wait_in[t][scan_idx] = 1'b0;
                        end
                     end
                     finish = last;
                  end
                  FUNC_SLEEP: begin
                     for (int t = 0; t < TABLES; t++) begin
                        if (hit[t]) begin
                           word_in[t][scan_idx]  = opnd_ff;
                           sleep_in[t][scan_idx] = 1'b1;
                        end
                     end
                     finish = last;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
               if (finish) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  total_in     = notify_ff;
               end else begin
                  chosen_in   = chosen_ff;
                  idle_in     = idle_ff;
                  accepted_in = accepted_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp.valid        = rsp_valid_ff;
      rsp.chosen_task  = chosen_ff;
      rsp.is_idle      = idle_ff;
      rsp.accepted     = accepted_ff;
      rsp.notify_total = total_ff;
   end

endmodule

// ----- test/tb_two_class_round_robin_scheduler_core.sv -----
// tb_two_class_round_robin_scheduler_core: self-checking bench for the two-class scheduler
// a task table predictor in a scoreboard class checks every response in order
// depends on tcrr_pkg, tcrr_if.sv and two_class_round_robin_scheduler_core
`timescale 1ns / 100ps

module tb_two_class_round_robin_scheduler_core;
   import tcrr_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
   localparam int RANDOM_REQUESTS = 1400;
   localparam int LIMIT_CYCLES    = 400000;
   localparam int SETTLE_CYCLES   = 3 * SLOTS + 8;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [TASK_W-1:0] task_id;
      logic              high_priority;
      logic [WORD_W-1:0] now_ticks;
      logic [WORD_W-1:0] reason;
      logic [WORD_W-1:0] check_count;
      logic [WORD_W-1:0] wake_time;
   } request_type;

   typedef struct packed {
      logic [TASK_W-1:0] chosen_task;
      logic              is_idle;
      logic              accepted;
      logic [WORD_W-1:0] notify_total;
   } response_type;

   class sched_scoreboard_type;
      bit              slot_used  [TABLES][SLOTS];
      bit [TASK_W-1:0] slot_task  [TABLES][SLOTS];
      bit              slot_wait  [TABLES][SLOTS];
      bit              slot_sleep [TABLES][SLOTS];
      bit [WORD_W-1:0] slot_word  [TABLES][SLOTS];
      bit [SLOT_W-1:0] scan_ptr;
      phase_type       phase;
      bit [WORD_W-1:0] notify_count;
      response_type    due_responses[$];
      int              errors;
      int              n_requests, n_schedules, n_idle, n_added, n_blocked, n_notifies;

      function new();
         scan_ptr     = '0;
         phase        = PH_H1;
         notify_count = '0;
         errors       = 0;
      endfunction

      function void note_request(request_type r);
         response_type res;
         logic         tbl;
         int           t;
         int           s;
         bit           found;
         res = '0;
         n_requests++;
         case (r.func)
            FUNC_SCHEDULE: begin
               n_schedules++;
               case (phase)
                  PH_H1:   phase = PH_L1;
                  PH_L1:   phase = PH_H2;
                  PH_H2:   phase = PH_L2;
                  PH_L2:   phase = PH_H3;
                  default: phase = PH_H1;
               endcase
               tbl = (phase == PH_L1 || phase == PH_L2) ? TBL_LOW : TBL_HIGH;
               found = 1'b0;
               for (s = 0; s < SLOTS && !found; s++) begin
                  scan_ptr = (scan_ptr == SLOTS - 1) ? '0 : scan_ptr + 1'b1;
                  if (slot_used[tbl][scan_ptr] && !slot_wait[tbl][scan_ptr] &&
                      (!slot_sleep[tbl][scan_ptr] ||
                       slot_word[tbl][scan_ptr] <= r.now_ticks)) begin
                     slot_sleep[tbl][scan_ptr] = 1'b0;
                     res.chosen_task = slot_task[tbl][scan_ptr];
                     found = 1'b1;
                  end
               end
               res.is_idle = !found;
               if (!found)
                  n_idle++;
            end
            FUNC_ADD: begin
               tbl = r.high_priority ? TBL_HIGH : TBL_LOW;
               for (s = 0; s < SLOTS && !res.accepted; s++) begin
                  if (!slot_used[tbl][s]) begin
                     slot_used[tbl][s]  = 1'b1;
                     slot_task[tbl][s]  = r.task_id;
                     slot_wait[tbl][s]  = 1'b0;
                     slot_sleep[tbl][s] = 1'b0;
                     slot_word[tbl][s]  = '0;
                     res.accepted = 1'b1;
                     n_added++;
                  end
               end
            end
            FUNC_EXIT: begin
               for (t = 0; t < TABLES; t++)
                  for (s = 0; s < SLOTS; s++)
                     if (slot_used[t][s] && slot_task[t][s] == r.task_id)
                        slot_used[t][s] = 1'b0;
            end
            FUNC_WAIT: begin
               if (r.check_count == notify_count) begin
                  for (t = 0; t < TABLES; t++)
                     for (s = 0; s < SLOTS; s++)
                        if (slot_used[t][s] && slot_task[t][s] == r.task_id) begin
                           slot_word[t][s] = r.reason;
                           slot_wait[t][s] = 1'b1;
                           res.accepted = 1'b1;
                        end
               end
               if (res.accepted)
                  n_blocked++;
            end
            FUNC_NOTIFY: begin
               n_notifies++;
               for (t = 0; t < TABLES; t++)
                  for (s = 0; s < SLOTS; s++)
                     if (slot_used[t][s] && slot_wait[t][s] && slot_word[t][s] == r.reason) begin
                        slot_word[t][s] = '0;
                        slot_wait[t][s] = 1'b0;
                     end
               notify_count = notify_count + 1'b1;
            end
            FUNC_SLEEP: begin
               for (t = 0; t < TABLES; t++)
                  for (s = 0; s < SLOTS; s++)
                     if (slot_used[t][s] && slot_task[t][s] == r.task_id) begin
                        slot_word[t][s]  = r.wake_time;
                        slot_sleep[t][s] = 1'b1;
                     end
            end
            default: ;
         endcase
         res.notify_total = notify_count;
         due_responses.push_back(res);
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (due_responses.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = due_responses.pop_front();
         if (got.chosen_task !== want.chosen_task) begin
            $error("chosen_task expected %0h got %0h", want.chosen_task, got.chosen_task);
            errors++;
         end
         if (got.is_idle !== want.is_idle) begin
            $error("is_idle expected %0b got %0b", want.is_idle, got.is_idle);
            errors++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted expected %0b got %0b", want.accepted, got.accepted);
            errors++;
         end
         if (got.notify_total !== want.notify_total) begin
            $error("notify_total expected %0h got %0h", want.notify_total, got.notify_total);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   tcrr_req_if req_ch ();
   tcrr_rsp_if rsp_ch ();

   two_class_round_robin_scheduler_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sched_scoreboard_type sb;
   int              cycle_count = 0;
   int              stall_mode  = 0;
   int              stall_left  = 0;
   bit [WORD_W-1:0] tick_now;
   bit [TASK_W-1:0] id_pool[10] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h3C,
                                    8'hA5, 8'h5A, 8'h7E, 8'h12, 8'hC3};
   bit [WORD_W-1:0] reason_pool[4] = '{32'h0000_0000, 32'h0000_0001,
                                       32'hFFFF_FFFF, 32'hA5C3_0F96};

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side stalls on its own pattern: free running, coin flips, periodic, sparse
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= (cycle_count % 7) > 3;
            default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response('{rsp_ch.chosen_task, rsp_ch.is_idle, rsp_ch.accepted,
                             rsp_ch.notify_total});
   end

   function automatic request_type mk(logic [FUNC_W-1:0] func, logic [TASK_W-1:0] id,
                                      logic hp, logic [WORD_W-1:0] now,
                                      logic [WORD_W-1:0] reason, logic [WORD_W-1:0] check,
                                      logic [WORD_W-1:0] wake);
      return '{func, id, hp, now, reason, check, wake};
   endfunction

   function automatic logic [TASK_W-1:0] pick_id();
      return ($urandom_range(0, 4) == 0) ? TASK_W'($urandom_range(0, 255))
                                         : id_pool[$urandom_range(0, 9)];
   endfunction

   function automatic logic [WORD_W-1:0] pick_reason();
      return ($urandom_range(0, 4) == 0) ? WORD_W'($urandom)
                                         : reason_pool[$urandom_range(0, 3)];
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      r = '{func: FUNC_SCHEDULE, task_id: pick_id(),
            high_priority: 1'($urandom_range(0, 1)),
            now_ticks: $urandom, reason: pick_reason(), check_count: $urandom,
            wake_time: $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.func = FUNC_W'($urandom_range(0, 7));
         r.task_id = TASK_W'($urandom_range(0, 255));
         r.reason = $urandom;
      end else if (pick < 45) begin
         r.func = FUNC_SCHEDULE;
         tick_now = tick_now + $urandom_range(0, 5);
         if ($urandom_range(0, 9) != 0)
            r.now_ticks = tick_now;
      end else if (pick < 60) begin
         r.func = FUNC_ADD;
      end else if (pick < 67) begin
         r.func = FUNC_EXIT;
      end else if (pick < 79) begin
         r.func = FUNC_WAIT;
         case ($urandom_range(0, 9))
            0:       ;
            1:       r.check_count = sb.notify_count + ($urandom_range(0, 1) ? 1 : -1);
            default: r.check_count = sb.notify_count;
         endcase
      end else if (pick < 89) begin
         r.func = FUNC_NOTIFY;
      end else begin
         r.func = FUNC_SLEEP;
         if ($urandom_range(0, 9) != 0)
            r.wake_time = tick_now + $urandom_range(0, 40);
      end
      return r;
   endfunction

   task automatic send_request(input request_type item);
      req_ch.valid         <= 1'b1;
      req_ch.func          <= item.func;
      req_ch.task_id       <= item.task_id;
      req_ch.high_priority <= item.high_priority;
      req_ch.now_ticks     <= item.now_ticks;
      req_ch.reason        <= item.reason;
      req_ch.check_count   <= item.check_count;
      req_ch.wake_time     <= item.wake_time;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic run_directed();
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_ADD, 8'h00, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_ADD, 8'hFF, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_ADD, 8'h5A, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_WAIT, 8'hFF, 1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_request(mk(FUNC_WAIT, 8'h00, 1'b0, 32'h0, 32'h5555_AAAA, 32'hFFFF_FFFF, 32'h0));
      send_request(mk(FUNC_WAIT, 8'h77, 1'b0, 32'h0, 32'h1, 32'h0, 32'h0));
      send_request(mk(FUNC_SLEEP, 8'h5A, 1'b0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_NOTIFY, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_NOTIFY, 8'hAA, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_WAIT, 8'h00, 1'b0, 32'h0, 32'h0000_1234, 32'h2, 32'h0));
      send_request(mk(FUNC_SLEEP, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_EXIT, 8'hFF, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_SPARE_A, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(mk(FUNC_SPARE_B, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
      send_request(mk(FUNC_NOTIFY, 8'h00, 1'b0, 32'h0, 32'h0000_1234, 32'h0, 32'h0));
      send_request(mk(FUNC_SCHEDULE, 8'h00, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0));
   endtask

   task automatic run_random();
      request_type item;
      int          counted;
      int          burst;
      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            item = random_request();
            send_request(item);
            if (item.func <= FUNC_SLEEP)
               counted++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8))
               @(posedge clock);
         end
      end
   endtask

   initial begin
      sb = new();
      tick_now = $urandom;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.func          <= FUNC_SCHEDULE;
      req_ch.task_id       <= '0;
      req_ch.high_priority <= 1'b0;
      req_ch.now_ticks     <= '0;
      req_ch.reason        <= '0;
      req_ch.check_count   <= '0;
      req_ch.wake_time     <= '0;
      repeat (12)
         @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_ch.valid <= 1'b0;
      while (sb.due_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      $display("%0d requests: %0d schedules (%0d idle), %0d tasks added, %0d waits blocked",
               sb.n_requests, sb.n_schedules, sb.n_idle, sb.n_added, sb.n_blocked);
      $display("%0d notifies, final notify count %0h, %0d cycles",
               sb.n_notifies, sb.notify_count, cycle_count);
      if (sb.errors == 0 && sb.due_responses.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/tcrr_pkg.sv
hdl/tcrr_if.sv
hdl/two_class_round_robin_scheduler_core.sv
test/tb_two_class_round_robin_scheduler_core.sv
